FILE: sv/letter_bag_similarity_counter_top_macros.svh
// ---------------------------------------------------------------------------
// letter bag similarity counter: assertion macros
// checks are clocked on aclk and disabled while aresetn is low
// ---------------------------------------------------------------------------
`ifndef LETTER_BAG_SIMILARITY_COUNTER_TOP_MACROS_SVH
`define LETTER_BAG_SIMILARITY_COUNTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// condition implies property in the same cycle
`define LBSC_ASSERT_NOW(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("lbsc assertion failed");

// condition implies property in the next cycle
`define LBSC_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("lbsc assertion failed");

`else

`define LBSC_ASSERT_NOW(name, cond, prop)
`define LBSC_ASSERT_NEXT(name, cond, prop)

`endif

`endif

FILE: sv/lbsc_pkg.sv
// ---------------------------------------------------------------------------
// lbsc_pkg
// constants and widths shared by the letter bag similarity counter
// ---------------------------------------------------------------------------
package lbsc_pkg;

    // alphabet and field widths
    localparam int unsigned LETTERS   = 26;
    localparam int unsigned CODE_W    = 5;

    // word length limit; letter counts and word lengths never exceed it
    localparam int unsigned MAX_LEN   = 16;
    localparam int unsigned LEN_W     = $clog2(MAX_LEN + 1);

    // saturation of the similar word count
    localparam int unsigned MAX_COUNT = 1023;
    localparam int unsigned TOT_W     = 10;

endpackage

FILE: sv/letter_bag_similarity_counter_top.sv
// ---------------------------------------------------------------------------
// letter_bag_similarity_counter_top
// letter multiset comparison of candidate words against a reference word
// ---------------------------------------------------------------------------
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  input   | s_valid s_ready s_letter_code s_is_reference  | in
//          | s_last_letter                                 |
//  result  | m_valid m_ready m_similar m_similar_total     | out
//          | m_missing_letters m_extra_letters             |
//          | m_length_overflow                             |
//
//  one letter per cycle sustained unless the input stalls; a letter is read
//  from the two count memories in the cycle it is taken, then updated and
//  written back from the update stage, with forwarding of the last write.
//  reset is synchronous, active low, and needs no clearing pass:
//  table clears are done through per-entry valid bits. the input stalls only
//  while a finished result waits in the output register and the letter in
//  the update stage would also produce one.
// ---------------------------------------------------------------------------
module letter_bag_similarity_counter_top
    import lbsc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // letter requests
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [4:0]        s_letter_code,
    input  logic              s_is_reference,
    input  logic              s_last_letter,
    // result requests
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_similar,
    output logic [9:0]        m_similar_total,
    output logic [4:0]        m_missing_letters,
    output logic [4:0]        m_extra_letters,
    output logic              m_length_overflow
);

`include "letter_bag_similarity_counter_top_macros.svh"

    // count memories and their valid bits
    logic [LEN_W-1:0]   ref_mem  [0:LETTERS-1];
    logic [LEN_W-1:0]   cand_mem [0:LETTERS-1];
    logic [LEN_W-1:0]   ref_rd_reg, cand_rd_reg;
    logic [LETTERS-1:0] ref_valid_reg, ref_valid_next;
    logic [LETTERS-1:0] cand_valid_reg, cand_valid_next;

    // update stage holding
    logic               s1_valid_reg;
    logic [CODE_W-1:0]  s1_code_reg;
    logic               s1_is_ref_reg;
    logic               s1_last_reg;

    // last write, for forwarding
    logic               fwd_ref_en_reg, fwd_cand_en_reg;
    logic [CODE_W-1:0]  fwd_code_reg;
    logic [LEN_W-1:0]   fwd_ref_val_reg, fwd_cand_val_reg;

    // word state
    logic [LEN_W-1:0]   ref_len_reg, ref_len_next;
    logic [LEN_W-1:0]   cand_len_reg, cand_len_next;
    logic [LEN_W-1:0]   missing_reg, missing_next;
    logic [LEN_W-1:0]   extra_reg, extra_next;
    logic [TOT_W-1:0]   sim_run_reg, sim_run_next;
    logic               mid_word_reg;
    logic               ovf_reg, ovf_next;

    // output register
    logic               m_valid_reg;
    logic               m_similar_reg;
    logic [TOT_W-1:0]   m_total_reg;
    logic [LEN_W-1:0]   m_missing_reg, m_extra_reg;
    logic               m_ovf_reg;

    // stage control and datapath
    logic               s_accept, s_in_range;
    logic               s1_go, s1_result, s1_in_range;
    logic               word_start, clr_ref;
    logic [LEN_W-1:0]   ref_cnt, cand_cnt, ref_cnt_next, cand_cnt_next;
    logic               wr_ref, wr_cand;
    logic               sim;

    // handshake
    assign s1_result  = s1_last_reg && !s1_is_ref_reg;
    assign s1_go      = s1_valid_reg && (!s1_result || !m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_go;
    assign s_accept   = s_valid && s_ready;
    assign s_in_range = s_letter_code < CODE_W'(LETTERS);

    // memory read on accept, write back from the update stage
    always_ff @(posedge aclk) begin
        if (s_accept && s_in_range) begin
            ref_rd_reg  <= ref_mem[s_letter_code];
            cand_rd_reg <= cand_mem[s_letter_code];
        end
        if (s1_go && wr_ref) begin
            ref_mem[s1_code_reg] <= ref_cnt_next;
        end
        if (s1_go && wr_cand) begin
            cand_mem[s1_code_reg] <= cand_cnt_next;
        end
    end

    // update: word start clears, then count the letter
    always_comb begin
        s1_in_range     = s1_code_reg < CODE_W'(LETTERS);
        word_start      = !mid_word_reg;
        clr_ref         = word_start && s1_is_ref_reg;

        ref_len_next    = clr_ref ? '0 : ref_len_reg;
        cand_len_next   = word_start ? '0 : cand_len_reg;
        missing_next    = word_start ? (s1_is_ref_reg ? '0 : ref_len_reg) : missing_reg;
        extra_next      = word_start ? '0 : extra_reg;
        sim_run_next    = clr_ref ? '0 : sim_run_reg;
        ovf_next        = clr_ref ? 1'b0 : ovf_reg;

        ref_valid_next  = clr_ref ? '0 : ref_valid_reg;
        cand_valid_next = word_start ? '0 : cand_valid_reg;

        // effective counts of this letter
        ref_cnt  = '0;
        cand_cnt = '0;
        if (s1_in_range) begin
            if (fwd_ref_en_reg && fwd_code_reg == s1_code_reg) begin
                ref_cnt = fwd_ref_val_reg;
            end else if (ref_valid_reg[s1_code_reg]) begin
                ref_cnt = ref_rd_reg;
            end
            if (fwd_cand_en_reg && fwd_code_reg == s1_code_reg) begin
                cand_cnt = fwd_cand_val_reg;
            end else if (cand_valid_reg[s1_code_reg]) begin
                cand_cnt = cand_rd_reg;
            end
        end
        if (clr_ref) begin
            ref_cnt = '0;
        end
        if (word_start) begin
            cand_cnt = '0;
        end

        ref_cnt_next  = ref_cnt + LEN_W'(1);
        cand_cnt_next = cand_cnt + LEN_W'(1);
        wr_ref        = 1'b0;
        wr_cand       = 1'b0;

        if (s1_in_range) begin
            if (s1_is_ref_reg) begin
                if (ref_len_next >= LEN_W'(MAX_LEN)) begin
                    ovf_next = 1'b1;
                end else begin
                    wr_ref = 1'b1;
                    if (cand_cnt > ref_cnt) begin
                        extra_next = extra_next - LEN_W'(1);
                    end else begin
                        missing_next = missing_next + LEN_W'(1);
                    end
                    ref_len_next = ref_len_next + LEN_W'(1);
                    ref_valid_next[s1_code_reg] = 1'b1;
                end
            end else begin
                if (cand_len_next >= LEN_W'(MAX_LEN)) begin
                    ovf_next = 1'b1;
                end else begin
                    wr_cand = 1'b1;
                    if (cand_cnt < ref_cnt) begin
                        missing_next = missing_next - LEN_W'(1);
                    end else begin
                        extra_next = extra_next + LEN_W'(1);
                    end
                    cand_len_next = cand_len_next + LEN_W'(1);
                    cand_valid_next[s1_code_reg] = 1'b1;
                end
            end
        end

        // verdict at the end of a candidate
        sim = (missing_next <= LEN_W'(1)) && (extra_next <= LEN_W'(1));
        if (s1_result && sim && sim_run_next < TOT_W'(MAX_COUNT)) begin
            sim_run_next = sim_run_next + TOT_W'(1);
        end
    end

    // update stage request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
        if (s_accept) begin
            s1_code_reg   <= s_letter_code;
            s1_is_ref_reg <= s_is_reference;
            s1_last_reg   <= s_last_letter;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_valid_reg   <= '0;
            cand_valid_reg  <= '0;
            fwd_ref_en_reg  <= 1'b0;
            fwd_cand_en_reg <= 1'b0;
            ref_len_reg     <= '0;
            cand_len_reg    <= '0;
            missing_reg     <= '0;
            extra_reg       <= '0;
            sim_run_reg     <= '0;
            mid_word_reg    <= 1'b0;
            ovf_reg         <= 1'b0;
        end else if (s1_go) begin
            ref_valid_reg   <= ref_valid_next;
            cand_valid_reg  <= cand_valid_next;
            fwd_ref_en_reg  <= wr_ref;
            fwd_cand_en_reg <= wr_cand;
            ref_len_reg     <= ref_len_next;
            cand_len_reg    <= cand_len_next;
            missing_reg     <= missing_next;
            extra_reg       <= extra_next;
            sim_run_reg     <= sim_run_next;
            mid_word_reg    <= !s1_last_reg;
            ovf_reg         <= ovf_next;
        end
    end

    // forwarded values
    always_ff @(posedge aclk) begin
        if (s1_go) begin
            fwd_code_reg     <= s1_code_reg;
            fwd_ref_val_reg  <= ref_cnt_next;
            fwd_cand_val_reg <= cand_cnt_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_go && s1_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (s1_go && s1_result) begin
            m_similar_reg <= sim;
            m_total_reg   <= sim_run_next;
            m_missing_reg <= missing_next;
            m_extra_reg   <= extra_next;
            m_ovf_reg     <= ovf_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_similar         = m_similar_reg;
    assign m_similar_total   = m_total_reg;
    assign m_missing_letters = m_missing_reg;
    assign m_extra_letters   = m_extra_reg;
    assign m_length_overflow = m_ovf_reg;

    // checks
    `LBSC_ASSERT_NOW(a_missing_bound, 1'b1, missing_reg <= ref_len_reg)
    `LBSC_ASSERT_NOW(a_ref_len_bound, 1'b1, ref_len_reg <= LEN_W'(MAX_LEN))
    `LBSC_ASSERT_NOW(a_cand_len_bound, 1'b1, cand_len_reg <= LEN_W'(MAX_LEN))
    `LBSC_ASSERT_NEXT(a_ref_clear, s1_go && clr_ref, $countones(ref_valid_reg) <= 1)
    `LBSC_ASSERT_NOW(a_sim_total, m_valid_reg && m_similar_reg, m_total_reg != '0)

endmodule
